/* sv/lease_grant_fencing_checker_macros.svh */
// Assertion macros shared by the lease checker RTL
`ifndef LEASE_GRANT_FENCING_CHECKER_MACROS_SVH
`define LEASE_GRANT_FENCING_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
`define LGFC_ASSERT(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("lease checker assertion failed");
`define LGFC_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lease checker implication failed");
`else
`define LGFC_ASSERT(name, expr)
`define LGFC_ASSERT_IMPL(name, ante, cons)
`endif
`endif

/* sv/lgfc_pkg.sv */
// Types and codes for the lease grant fencing checker
`timescale 1ns / 1ps
`default_nettype none
package lgfc_pkg;

	typedef enum logic [1:0] {
		FUNC_ISSUE   = 2'd0,
		FUNC_ACCEPT  = 2'd1,
		FUNC_RENEW   = 2'd2,
		FUNC_RECOVER = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_OK              = 4'd0,
		ST_RECOVERY        = 4'd1,
		ST_CLOCK_BREAK     = 4'd2,
		ST_NO_GRANT        = 4'd3,
		ST_EXPIRED         = 4'd4,
		ST_ENTITY          = 4'd5,
		ST_OWNER           = 4'd6,
		ST_REVISION        = 4'd7,
		ST_SEQUENCE        = 4'd8,
		ST_FIELD           = 4'd9,
		ST_ISSUE_REFUSED   = 4'd10,
		ST_RECOVER_REFUSED = 4'd11
	} status_t;

	localparam logic REG_OWN_ENTITY   = 1'b0;
	localparam logic REG_LEASE_LENGTH = 1'b1;

	localparam logic [31:0] OWN_ENTITY_RST   = 32'd1;
	localparam logic [31:0] LEASE_LENGTH_RST = 32'd100000;

	typedef struct packed {
		func_t       func;
		logic [31:0] clock_domain;
		logic [63:0] clock_time;
		logic [31:0] entity_id;
		logic [31:0] session_id;
		logic [31:0] owner_epoch;
		logic [31:0] catalog_rev;
		logic [31:0] state_rev;
		logic [63:0] field_set;
		logic [31:0] sequence_num;
		logic        applied_flag;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] granted_owner;
		logic [63:0] deadline_time;
		logic [31:0] deadline_domain;
	} result_t;

endpackage
`default_nettype wire

/* sv/lease_grant_fencing_checker.sv */
// Lease grant checker with clock fencing: input register, decision logic, result register
// Usage:
//   Commands arrive on the in_valid/in_ready channel, one field per port; each
//   transfer gives exactly one result on the out_valid/out_ready channel.
//   Configuration (own_entity index 0, lease_length index 1) is written through
//   cfg_we/cfg_idx/cfg_wdata while no command is in flight.
//   Path: a command accepted into the input register is decided combinationally
//   and its result registered once the result register is free, raising out_valid.
//   Throughput: one command per cycle while out_ready is high; the lease state
//   registers are read and updated by the decision logic once per decided command.
//   Reset: the block comes up fenced with no grant; only recover with a nonzero
//   clock domain unfences it. Configuration returns to own_entity 1 and
//   lease_length 100000.
//   Stall: while out_ready is low the result is held, one more command may sit
//   in the input register, and in_ready drops once that register is full.
`timescale 1ns / 1ps
`default_nettype none
`include "lease_grant_fencing_checker_macros.svh"
module lease_grant_fencing_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] clock_domain,
	input  wire logic [63:0] clock_time,
	input  wire logic [31:0] entity_id,
	input  wire logic [31:0] session_id,
	input  wire logic [31:0] owner_epoch,
	input  wire logic [31:0] catalog_rev,
	input  wire logic [31:0] state_rev,
	input  wire logic [63:0] field_set,
	input  wire logic [31:0] sequence_num,
	input  wire logic        applied_flag,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       status,
	output logic [31:0]      granted_owner,
	output logic [63:0]      deadline_time,
	output logic [31:0]      deadline_domain
);

	logic [31:0] own_entity_q, lease_length_q;

	logic              valid_s1;
	lgfc_pkg::item_t   item_s1;
	logic              valid_s2;
	lgfc_pkg::result_t res_s2;

	logic        fenced_q, grant_valid_q;
	logic [31:0] stamp_domain_q;
	logic [63:0] stamp_time_q;
	logic [31:0] grant_session_q, grant_owner_q, grant_catalog_q, grant_state_q;
	logic [63:0] grant_mask_q, grant_deadline_q;
	logic [31:0] last_owner_q, last_motion_q, last_renewal_q;

	logic        fenced_d, grant_valid_d;
	logic [31:0] stamp_domain_d;
	logic [63:0] stamp_time_d;
	logic [31:0] grant_session_d, grant_owner_d, grant_catalog_d, grant_state_d;
	logic [63:0] grant_mask_d, grant_deadline_d;
	logic [31:0] last_owner_d, last_motion_d, last_renewal_d;

	logic              fire_s1;
	logic              sample_ok, clk_break, issue_ok;
	logic [64:0]       sum;
	lgfc_pkg::result_t res_d;

	assign fire_s1  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	assign sum       = {1'b0, item_s1.clock_time} + {33'd0, lease_length_q};
	assign sample_ok = !fenced_q && item_s1.clock_domain == stamp_domain_q &&
		item_s1.clock_time >= stamp_time_q;
	assign clk_break = !fenced_q && !sample_ok;
	assign issue_ok  = item_s1.func == lgfc_pkg::FUNC_ISSUE && sample_ok &&
		item_s1.applied_flag && item_s1.session_id != '0 && item_s1.catalog_rev != '0 &&
		item_s1.state_rev != '0 && item_s1.field_set != '0 &&
		last_owner_q != '1 && !sum[64];

	always_comb begin
		fenced_d         = fenced_q;
		grant_valid_d    = grant_valid_q;
		stamp_domain_d   = stamp_domain_q;
		stamp_time_d     = stamp_time_q;
		grant_session_d  = grant_session_q;
		grant_owner_d    = grant_owner_q;
		grant_catalog_d  = grant_catalog_q;
		grant_state_d    = grant_state_q;
		grant_mask_d     = grant_mask_q;
		grant_deadline_d = grant_deadline_q;
		last_owner_d     = last_owner_q;
		last_motion_d    = last_motion_q;
		last_renewal_d   = last_renewal_q;
		res_d            = '{status: lgfc_pkg::ST_OK, granted_owner: '0,
			deadline_time: '0, deadline_domain: '0};

		if (item_s1.func != lgfc_pkg::FUNC_RECOVER) begin
			if (sample_ok) begin
				stamp_domain_d = item_s1.clock_domain;
				stamp_time_d   = item_s1.clock_time;
			end
			if (clk_break) begin
				fenced_d      = 1'b1;
				grant_valid_d = 1'b0;
			end
		end

		unique case (item_s1.func)
			lgfc_pkg::FUNC_ISSUE: begin
				if (!sample_ok || !item_s1.applied_flag || item_s1.session_id == '0 ||
						item_s1.catalog_rev == '0 || item_s1.state_rev == '0 ||
						item_s1.field_set == '0) begin
					res_d.status = lgfc_pkg::ST_ISSUE_REFUSED;
				end else if (last_owner_q == '1 || sum[64]) begin
					fenced_d      = 1'b1;
					grant_valid_d = 1'b0;
					res_d.status  = lgfc_pkg::ST_ISSUE_REFUSED;
				end else begin
					last_owner_d           = last_owner_q + 32'd1;
					last_motion_d          = '0;
					last_renewal_d         = '0;
					grant_valid_d          = 1'b1;
					grant_session_d        = item_s1.session_id;
					grant_owner_d          = last_owner_q + 32'd1;
					grant_catalog_d        = item_s1.catalog_rev;
					grant_state_d          = item_s1.state_rev;
					grant_mask_d           = item_s1.field_set;
					grant_deadline_d       = sum[63:0];
					res_d.granted_owner    = last_owner_q + 32'd1;
					res_d.deadline_time    = sum[63:0];
					res_d.deadline_domain  = item_s1.clock_domain;
				end
			end
			lgfc_pkg::FUNC_ACCEPT, lgfc_pkg::FUNC_RENEW: begin
				if (fenced_q) begin
					res_d.status = lgfc_pkg::ST_RECOVERY;
				end else if (clk_break) begin
					res_d.status = lgfc_pkg::ST_CLOCK_BREAK;
				end else if (!grant_valid_q) begin
					res_d.status = lgfc_pkg::ST_NO_GRANT;
				end else if (item_s1.clock_time >= grant_deadline_q) begin
					grant_valid_d = 1'b0;
					res_d.status  = lgfc_pkg::ST_EXPIRED;
				end else if (item_s1.func == lgfc_pkg::FUNC_ACCEPT) begin
					if (item_s1.entity_id != own_entity_q) begin
						res_d.status = lgfc_pkg::ST_ENTITY;
					end else if (item_s1.session_id != grant_session_q ||
							item_s1.owner_epoch != grant_owner_q) begin
						res_d.status = lgfc_pkg::ST_OWNER;
					end else if (item_s1.catalog_rev != grant_catalog_q ||
							item_s1.state_rev != grant_state_q) begin
						res_d.status = lgfc_pkg::ST_REVISION;
					end else if (item_s1.sequence_num <= last_motion_q) begin
						res_d.status = lgfc_pkg::ST_SEQUENCE;
					end else if (item_s1.field_set == '0 ||
							(item_s1.field_set & ~grant_mask_q) != '0) begin
						res_d.status = lgfc_pkg::ST_FIELD;
					end else begin
						last_motion_d = item_s1.sequence_num;
					end
				end else begin
					if (item_s1.session_id != grant_session_q ||
							item_s1.owner_epoch != grant_owner_q) begin
						res_d.status = lgfc_pkg::ST_OWNER;
					end else if (item_s1.sequence_num <= last_renewal_q) begin
						res_d.status = lgfc_pkg::ST_SEQUENCE;
					end else if (sum[64]) begin
						fenced_d      = 1'b1;
						grant_valid_d = 1'b0;
						res_d.status  = lgfc_pkg::ST_RECOVERY;
					end else begin
						last_renewal_d        = item_s1.sequence_num;
						grant_deadline_d      = sum[63:0];
						res_d.deadline_time   = sum[63:0];
						res_d.deadline_domain = item_s1.clock_domain;
					end
				end
			end
			lgfc_pkg::FUNC_RECOVER: begin
				if (item_s1.clock_domain == '0) begin
					res_d.status = lgfc_pkg::ST_RECOVER_REFUSED;
				end else begin
					stamp_domain_d = item_s1.clock_domain;
					stamp_time_d   = item_s1.clock_time;
					grant_valid_d  = 1'b0;
					fenced_d       = 1'b0;
				end
			end
			default: begin
				res_d.status = lgfc_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_entity_q   <= lgfc_pkg::OWN_ENTITY_RST;
			lease_length_q <= lgfc_pkg::LEASE_LENGTH_RST;
		end else if (cfg_we) begin
			if (cfg_idx == lgfc_pkg::REG_OWN_ENTITY) begin
				own_entity_q <= cfg_wdata;
			end
			if (cfg_idx == lgfc_pkg::REG_LEASE_LENGTH) begin
				lease_length_q <= cfg_wdata;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{func: lgfc_pkg::func_t'(func), clock_domain: clock_domain,
				clock_time: clock_time, entity_id: entity_id, session_id: session_id,
				owner_epoch: owner_epoch, catalog_rev: catalog_rev, state_rev: state_rev,
				field_set: field_set, sequence_num: sequence_num,
				applied_flag: applied_flag};
		end
	end

	// lease state, advanced once per decided command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fenced_q         <= 1'b1;
			grant_valid_q    <= 1'b0;
			stamp_domain_q   <= '0;
			stamp_time_q     <= '0;
			grant_session_q  <= '0;
			grant_owner_q    <= '0;
			grant_catalog_q  <= '0;
			grant_state_q    <= '0;
			grant_mask_q     <= '0;
			grant_deadline_q <= '0;
			last_owner_q     <= '0;
			last_motion_q    <= '0;
			last_renewal_q   <= '0;
		end else if (fire_s1) begin
			fenced_q         <= fenced_d;
			grant_valid_q    <= grant_valid_d;
			stamp_domain_q   <= stamp_domain_d;
			stamp_time_q     <= stamp_time_d;
			grant_session_q  <= grant_session_d;
			grant_owner_q    <= grant_owner_d;
			grant_catalog_q  <= grant_catalog_d;
			grant_state_q    <= grant_state_d;
			grant_mask_q     <= grant_mask_d;
			grant_deadline_q <= grant_deadline_d;
			last_owner_q     <= last_owner_d;
			last_motion_q    <= last_motion_d;
			last_renewal_q   <= last_renewal_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid       = valid_s2;
	assign status          = res_s2.status;
	assign granted_owner   = res_s2.granted_owner;
	assign deadline_time   = res_s2.deadline_time;
	assign deadline_domain = res_s2.deadline_domain;

	`LGFC_ASSERT_IMPL(a_fence_drops_grant, fenced_q, !grant_valid_q)
	`LGFC_ASSERT_IMPL(a_ready_when_out_empty, !valid_s2, in_ready)
	`LGFC_ASSERT_IMPL(a_owner_only_on_ok, valid_s2 && granted_owner != '0,
		status == lgfc_pkg::ST_OK)
	`LGFC_ASSERT(a_epoch_advance,
		(fire_s1 && issue_ok) |=> last_owner_q == $past(last_owner_q) + 32'd1)

endmodule
`default_nettype wire
